>>> rtl/core/svdms_pkg.sv
// ----------------------------------------------------------------------------
// svdms_pkg: shared types and constants
// Type codes, fixed-point limits and the words passed between the front
// decoder, the queue and the back end of the sensor value decoder.
// ----------------------------------------------------------------------------
package svdms_pkg;

   // Four-character type codes, first character in the top byte
   localparam logic [31:0] TYPE_FLT  = 32'h666C_7420;  // "flt "
   localparam logic [31:0] TYPE_SP78 = 32'h7370_3738;  // "sp78"
   localparam logic [31:0] TYPE_FPE2 = 32'h6670_6532;  // "fpe2"
   localparam logic [31:0] TYPE_UI32 = 32'h7569_3332;  // "ui32"
   localparam logic [31:0] TYPE_UI8  = 32'h7569_3820;  // "ui8 "

   // Data sizes in bytes for each format
   localparam logic [5:0] SIZE_FLT  = 6'd4;
   localparam logic [5:0] SIZE_SP78 = 6'd2;
   localparam logic [5:0] SIZE_FPE2 = 6'd2;
   localparam logic [5:0] SIZE_UI32 = 6'd4;
   localparam logic [5:0] SIZE_UI8  = 6'd1;

   // Key prefixes that take part in the scan
   localparam logic [7:0] KEY_UPPER_T = 8'h54;
   localparam logic [7:0] KEY_LOWER_T = 8'h74;

   // Float exponent codes
   localparam logic [7:0] EXP_SPECIAL = 8'hFF;
   localparam logic [7:0] EXP_SAT     = 8'd165;  // above this the Q.8 range overflows

   // Q.8 limits
   localparam logic signed [47:0] Q8_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] Q8_MIN = 48'sh8000_0000_0000;

   // Register indexes on the configuration port
   localparam logic [7:0] CSR_SINGLE_LOW  = 8'd0;
   localparam logic [7:0] CSR_SINGLE_HIGH = 8'd1;
   localparam logic [7:0] CSR_SCAN_LOW    = 8'd2;
   localparam logic [7:0] CSR_SCAN_HIGH   = 8'd3;

   // Register reset values, degrees
   localparam logic signed [7:0] RST_SINGLE_LOW  = -8'sd40;
   localparam logic signed [7:0] RST_SINGLE_HIGH = 8'sd125;
   localparam logic signed [7:0] RST_SCAN_LOW    = 8'sd5;
   localparam logic signed [7:0] RST_SCAN_HIGH   = 8'sd120;

   // Default queue depth between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Window registers
   typedef struct packed {
      logic signed [7:0] single_low;
      logic signed [7:0] single_high;
      logic signed [7:0] scan_low;
      logic signed [7:0] scan_high;
   } cfg_type;

   // Decoded word from front to back
   typedef struct packed {
      logic               decoded;
      logic               finite;
      logic signed [47:0] value_q8;
      logic               key_t;
      logic               last;
   } dec_word_type;

endpackage

>>> rtl/core/svdms_front.sv
// ----------------------------------------------------------------------------
// svdms_front: entry decoder
// Accepts key entries, matches type and size against the known formats and
// converts the value to signed Q.8 into a one-word holding register.
// ----------------------------------------------------------------------------
module svdms_front (
   input  logic                       clock,
   input  logic                       reset,
   // entry channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_entry_valid,
   input  logic [7:0]                 req_key_first_char,
   input  logic [31:0]                req_type_code,
   input  logic [5:0]                 req_data_size,
   input  logic [31:0]                req_data_word,
   input  logic                       req_last,
   // to queue
   output logic                       push,
   output svdms_pkg::dec_word_type    push_word,
   input  logic                       q_full
);
   import svdms_pkg::*;

   logic          hold_valid_ff;
   logic          hold_valid_in;
   dec_word_type  hold_ff;
   dec_word_type  hold_in;
   logic          accept;

   // float conversion signals
   logic [7:0]    exp_raw;
   logic [7:0]    exp_eff;
   logic [23:0]   sig;
   logic [7:0]    shr_amt;
   logic [46:0]   mag;
   logic signed [47:0] flt_q8;

   // Float to Q.8: the significand sits at bit 23 of a 47-bit word, a right
   // shift by (165 - exponent) gives the magnitude truncated toward zero
   always_comb begin
      exp_raw = req_data_word[30:23];
      exp_eff = (exp_raw == 8'd0) ? 8'd1 : exp_raw;
      sig     = {exp_raw != 8'd0, req_data_word[22:0]};
      shr_amt = EXP_SAT - exp_eff;
      mag     = {sig, 23'd0} >> shr_amt;
      if (exp_eff > EXP_SAT) begin
         flt_q8 = req_data_word[31] ? Q8_MIN : Q8_MAX;
      end else if (req_data_word[31]) begin
         flt_q8 = -$signed({1'b0, mag});
      end else begin
         flt_q8 = $signed({1'b0, mag});
      end
   end

   // Format match and decode
   always_comb begin
      hold_in          = '0;
      hold_in.finite   = 1'b1;
      hold_in.last     = req_last;
      hold_in.key_t    = (req_key_first_char == KEY_UPPER_T) ||
                         (req_key_first_char == KEY_LOWER_T);
      if (req_entry_valid) begin
         unique case (req_type_code)
            TYPE_FLT: begin
               if (req_data_size == SIZE_FLT) begin
                  hold_in.decoded = 1'b1;
                  if (exp_raw == EXP_SPECIAL) begin
                     hold_in.finite = 1'b0;
                  end else begin
                     hold_in.value_q8 = flt_q8;
                  end
               end
            end
            TYPE_SP78: begin
               if (req_data_size == SIZE_SP78) begin
                  hold_in.decoded  = 1'b1;
                  hold_in.value_q8 = 48'($signed(req_data_word[31:16]));
               end
            end
            TYPE_FPE2: begin
               if (req_data_size == SIZE_FPE2) begin
                  hold_in.decoded  = 1'b1;
                  hold_in.value_q8 = $signed({26'd0, req_data_word[31:16], 6'd0});
               end
            end
            TYPE_UI32: begin
               if (req_data_size == SIZE_UI32) begin
                  hold_in.decoded  = 1'b1;
                  hold_in.value_q8 = $signed({8'd0, req_data_word, 8'd0});
               end
            end
            TYPE_UI8: begin
               if (req_data_size == SIZE_UI8) begin
                  hold_in.decoded  = 1'b1;
                  hold_in.value_q8 = $signed({32'd0, req_data_word[31:24], 8'd0});
               end
            end
            default: begin
               hold_in.decoded = 1'b0;
            end
         endcase
      end
   end

   // Holding register drains into the queue unless it is full
   assign push      = hold_valid_ff && !q_full;
   assign push_word = hold_ff;
   assign req_stall = hold_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

endmodule

>>> rtl/core/svdms_queue.sv
// ----------------------------------------------------------------------------
// svdms_queue: decoded word queue
// Short first-in first-out store between the front decoder and the back end,
// so that each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module svdms_queue #(
   parameter int DEPTH = svdms_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  svdms_pkg::dec_word_type    push_word,
   output logic                       full,
   input  logic                       pop,
   output logic                       pop_valid,
   output svdms_pkg::dec_word_type    pop_word
);
   import svdms_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dec_word_type       slot_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff;
   logic [IDX_W-1:0]   wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff;
   logic [IDX_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = slot_ff[rd_ptr_ff];

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   // Checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not advance on write");

endmodule

>>> rtl/core/svdms_back.sv
// ----------------------------------------------------------------------------
// svdms_back: window checks and maximum scan
// Takes decoded words from the queue, applies the single read window with
// rounding, tracks the running maximum and drives the result register.
// ----------------------------------------------------------------------------
module svdms_back (
   input  logic                       clock,
   input  logic                       reset,
   input  svdms_pkg::cfg_type         cfg,
   // from queue
   input  logic                       pop_valid,
   input  svdms_pkg::dec_word_type    pop_word,
   output logic                       pop,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_decoded,
   output logic                       rsp_finite,
   output logic signed [47:0]         rsp_value_q8,
   output logic                       rsp_single_ok,
   output logic signed [7:0]          rsp_single_c,
   output logic                       rsp_scan_done,
   output logic                       rsp_scan_found,
   output logic signed [7:0]          rsp_scan_c
);
   import svdms_pkg::*;

   typedef struct packed {
      logic               decoded;
      logic               finite;
      logic signed [47:0] value_q8;
      logic               single_ok;
      logic signed [7:0]  single_c;
      logic               scan_done;
      logic               scan_found;
      logic signed [7:0]  scan_c;
   } rsp_word_type;

   rsp_word_type        out_ff;
   rsp_word_type        out_in;
   logic                rsp_valid_ff;
   logic signed [47:0]  best_ff;
   logic signed [47:0]  best_in;
   logic                found_ff;
   logic                found_in;
   logic                out_ready;
   logic                usable;
   logic                qualify;

   // Degrees to Q.8 threshold
   function automatic logic signed [47:0] deg_to_q8(input logic signed [7:0] d);
      return $signed({{32{d[7]}}, d, 8'd0});
   endfunction

   // (v + 0.5) truncated toward zero; v is known to lie in the 8-bit range
   function automatic logic signed [7:0] round_q8(input logic signed [47:0] v);
      logic signed [17:0] t;
      logic signed [9:0]  q;
      t = $signed({v[16], v[16:0]}) + 18'sd128;
      q = t[17:8];
      if (t[17] && (t[7:0] != 8'd0)) begin
         q = q + 10'sd1;
      end
      return q[7:0];
   endfunction

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign pop       = pop_valid && out_ready;
   assign usable    = pop_word.decoded && pop_word.finite;

   // Scan qualification and running maximum
   always_comb begin
      qualify = usable && pop_word.key_t &&
                (pop_word.value_q8 >= deg_to_q8(cfg.scan_low)) &&
                (pop_word.value_q8 <= deg_to_q8(cfg.scan_high)) &&
                (pop_word.value_q8 > best_ff);
      best_in  = qualify ? pop_word.value_q8 : best_ff;
      found_in = found_ff || qualify;
   end

   // Result word
   always_comb begin
      out_in            = '0;
      out_in.decoded    = pop_word.decoded;
      out_in.finite     = pop_word.finite;
      out_in.value_q8   = pop_word.value_q8;
      out_in.single_ok  = usable &&
                          (pop_word.value_q8 > deg_to_q8(cfg.single_low)) &&
                          (pop_word.value_q8 < deg_to_q8(cfg.single_high));
      out_in.single_c   = out_in.single_ok ? round_q8(pop_word.value_q8) : '0;
      out_in.scan_done  = pop_word.last;
      out_in.scan_found = pop_word.last && found_in;
      out_in.scan_c     = (pop_word.last && found_in) ? round_q8(best_in) : '0;
   end

   // Scan state, cleared after the last word of a scan
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= Q8_MIN;
         found_ff <= 1'b0;
      end else if (pop) begin
         if (pop_word.last) begin
            best_ff  <= Q8_MIN;
            found_ff <= 1'b0;
         end else begin
            best_ff  <= best_in;
            found_ff <= found_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_decoded    = out_ff.decoded;
   assign rsp_finite     = out_ff.finite;
   assign rsp_value_q8   = out_ff.value_q8;
   assign rsp_single_ok  = out_ff.single_ok;
   assign rsp_single_c   = out_ff.single_c;
   assign rsp_scan_done  = out_ff.scan_done;
   assign rsp_scan_found = out_ff.scan_found;
   assign rsp_scan_c     = out_ff.scan_c;

   // Checks
   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_single_ok) |-> (rsp_single_c == 8'sd0))
      else $error("rejected single read with nonzero rounding");

   a_scan_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_scan_done) |-> (!rsp_scan_found && (rsp_scan_c == 8'sd0)))
      else $error("scan result outside last word");

   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_word.last) |=> (!found_ff && (best_ff == Q8_MIN)))
      else $error("scan state not cleared after last word");

endmodule

>>> rtl/core/sensor_value_decode_and_max_scan.sv
// ----------------------------------------------------------------------------
// sensor_value_decode_and_max_scan: sensor entry decoder with maximum scan
// Decodes sensor key entries to signed Q.8 and reports a windowed maximum.
// ----------------------------------------------------------------------------
// Takes one key entry word per clock while req_stall is low and returns one
// result word per entry, in order. An accepted entry passes through the
// front holding register, then the queue, then the result register, which
// presents the word with rsp_valid. The front decoder and back end are split
// by a queue of QUEUE_DEPTH words, so a stalled result side lets the block
// hold up to QUEUE_DEPTH + 2 words (result register, queue and front
// register) before req_stall rises. Window registers are written over the
// csr_ port, which is always ready; writes should be made only while no
// entries are in flight. Indexes above 3 are ignored.
// ----------------------------------------------------------------------------
module sensor_value_decode_and_max_scan #(
   parameter int QUEUE_DEPTH = svdms_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // entry channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_entry_valid,
   input  logic [7:0]          req_key_first_char,
   input  logic [31:0]         req_type_code,
   input  logic [5:0]          req_data_size,
   input  logic [31:0]         req_data_word,
   input  logic                req_last,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_decoded,
   output logic                rsp_finite,
   output logic signed [47:0]  rsp_value_q8,
   output logic                rsp_single_ok,
   output logic signed [7:0]   rsp_single_c,
   output logic                rsp_scan_done,
   output logic                rsp_scan_found,
   output logic signed [7:0]   rsp_scan_c,
   // register write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_wdata
);
   import svdms_pkg::*;

   cfg_type       cfg_ff;
   dec_word_type  push_word;
   dec_word_type  pop_word;
   logic          push;
   logic          pop;
   logic          q_full;
   logic          pop_valid;

   // Window registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.single_low  <= RST_SINGLE_LOW;
         cfg_ff.single_high <= RST_SINGLE_HIGH;
         cfg_ff.scan_low    <= RST_SCAN_LOW;
         cfg_ff.scan_high   <= RST_SCAN_HIGH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SINGLE_LOW:  cfg_ff.single_low  <= $signed(csr_wdata);
            CSR_SINGLE_HIGH: cfg_ff.single_high <= $signed(csr_wdata);
            CSR_SCAN_LOW:    cfg_ff.scan_low    <= $signed(csr_wdata);
            CSR_SCAN_HIGH:   cfg_ff.scan_high   <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Front decoder
   svdms_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_entry_valid    (req_entry_valid),
      .req_key_first_char (req_key_first_char),
      .req_type_code      (req_type_code),
      .req_data_size      (req_data_size),
      .req_data_word      (req_data_word),
      .req_last           (req_last),
      .push               (push),
      .push_word          (push_word),
      .q_full             (q_full)
   );

   // Decoupling queue
   svdms_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_word  (pop_word)
   );

   // Back end
   svdms_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pop_valid      (pop_valid),
      .pop_word       (pop_word),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_decoded    (rsp_decoded),
      .rsp_finite     (rsp_finite),
      .rsp_value_q8   (rsp_value_q8),
      .rsp_single_ok  (rsp_single_ok),
      .rsp_single_c   (rsp_single_c),
      .rsp_scan_done  (rsp_scan_done),
      .rsp_scan_found (rsp_scan_found),
      .rsp_scan_c     (rsp_scan_c)
   );

endmodule

>>> bench/svdms_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svdms_checker: result predictor and scoreboard for the sensor decoder
// Watches the entry, result and register channels of the sensor value
// decoder, works out the expected result word for each accepted entry and
// compares every accepted result word with the oldest expectation.
// ----------------------------------------------------------------------------
module svdms_checker (
   input  logic               clock,
   input  logic               reset,
   // entry channel
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_entry_valid,
   input  logic [7:0]         req_key_first_char,
   input  logic [31:0]        req_type_code,
   input  logic [5:0]         req_data_size,
   input  logic [31:0]        req_data_word,
   input  logic               req_last,
   // result channel
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_decoded,
   input  logic               rsp_finite,
   input  logic signed [47:0] rsp_value_q8,
   input  logic               rsp_single_ok,
   input  logic signed [7:0]  rsp_single_c,
   input  logic               rsp_scan_done,
   input  logic               rsp_scan_found,
   input  logic signed [7:0]  rsp_scan_c,
   // register channel
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   // status for the bench top
   output int                 fail_count,
   output int                 outstanding,
   output int                 results_checked,
   output int                 scans_closed
);
   import svdms_pkg::*;

   // One expected result word
   typedef struct packed {
      logic               decoded;
      logic               finite;
      logic signed [47:0] value_q8;
      logic               single_ok;
      logic signed [7:0]  single_c;
      logic               scan_done;
      logic               scan_found;
      logic signed [7:0]  scan_c;
   } reading_type;

   // Window copies, degrees
   int win_single_low;
   int win_single_high;
   int win_scan_low;
   int win_scan_high;

   // Running maximum of the current scan
   longint scan_best_q8;
   bit     scan_any;

   reading_type expected_readings[$];
   int          mismatches;
   int          checked;
   int          closed;

   // IEEE single to Q.8, truncated toward zero, saturated at the 48-bit range
   function automatic longint float_bits_to_q8(input logic [31:0] bits);
      int               expo;
      int               sh;
      longint unsigned  mant;
      longint unsigned  mag;
      expo = int'(bits[30:23]);
      mant = 64'(bits[22:0]);
      if (expo == 0) begin
         expo = 1;
      end else begin
         mant[23] = 1'b1;
      end
      sh = expo - 142;
      if (sh > 23) begin
         return bits[31] ? longint'(Q8_MIN) : longint'(Q8_MAX);
      end
      if (sh >= 0) begin
         mag = mant << sh;
      end else if (-sh >= 32) begin
         mag = 0;
      end else begin
         mag = mant >> (-sh);
      end
      return bits[31] ? -longint'(mag) : longint'(mag);
   endfunction

   // Add a half and truncate toward zero, degrees
   function automatic logic signed [7:0] round_to_deg(input longint q8);
      longint deg;
      deg = (q8 + 128) / 256;
      return deg[7:0];
   endfunction

   // Expected word for one entry; advances the scan state
   function automatic reading_type predict_reading(
      input logic        entry_ok,
      input logic [7:0]  key,
      input logic [31:0] kind,
      input logic [5:0]  size,
      input logic [31:0] word,
      input logic        last
   );
      reading_type r;
      longint      v;
      v = 0;
      r = '0;
      r.finite = 1'b1;
      if (entry_ok) begin
         if (kind == TYPE_FLT && size == SIZE_FLT) begin
            r.decoded = 1'b1;
            if (word[30:23] == EXP_SPECIAL) begin
               r.finite = 1'b0;
            end else begin
               v = float_bits_to_q8(word);
            end
         end else if (kind == TYPE_SP78 && size == SIZE_SP78) begin
            r.decoded = 1'b1;
            v = longint'($signed(word[31:16]));
         end else if (kind == TYPE_FPE2 && size == SIZE_FPE2) begin
            r.decoded = 1'b1;
            v = 64'(word[31:16]) * 64;
         end else if (kind == TYPE_UI32 && size == SIZE_UI32) begin
            r.decoded = 1'b1;
            v = 64'(word) * 256;
         end else if (kind == TYPE_UI8 && size == SIZE_UI8) begin
            r.decoded = 1'b1;
            v = 64'(word[31:24]) * 256;
         end
      end

      // single read window and scan update
      if (r.decoded && r.finite) begin
         if (v > win_single_low * 256 && v < win_single_high * 256) begin
            r.single_ok = 1'b1;
            r.single_c  = round_to_deg(v);
         end
         if ((key == KEY_UPPER_T || key == KEY_LOWER_T) &&
             v >= win_scan_low * 256 && v <= win_scan_high * 256 &&
             v > scan_best_q8) begin
            scan_best_q8 = v;
            scan_any     = 1'b1;
         end
      end
      r.value_q8 = v[47:0];

      // scan report, then clear
      r.scan_done = last;
      if (last) begin
         r.scan_found = scan_any;
         if (scan_any) begin
            r.scan_c = round_to_deg(scan_best_q8);
         end
         scan_best_q8 = longint'(Q8_MIN);
         scan_any     = 1'b0;
      end
      return r;
   endfunction

   task automatic compare_field(
      input string              field,
      input logic signed [63:0] want,
      input logic signed [63:0] got
   );
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Sample all three channels at the clock edge
   always @(posedge clock) begin : watch
      reading_type want;
      if (reset) begin
         win_single_low  = int'(RST_SINGLE_LOW);
         win_single_high = int'(RST_SINGLE_HIGH);
         win_scan_low    = int'(RST_SCAN_LOW);
         win_scan_high   = int'(RST_SCAN_HIGH);
         scan_best_q8    = longint'(Q8_MIN);
         scan_any        = 1'b0;
         expected_readings.delete();
      end else begin
         // result side first, so a stray word cannot match a fresh entry
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("result word with no entry outstanding");
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               compare_field("decoded", 64'(want.decoded), 64'(rsp_decoded));
               compare_field("finite", 64'(want.finite), 64'(rsp_finite));
               compare_field("value_q8", 64'($signed(want.value_q8)),
                             64'(rsp_value_q8));
               compare_field("single_ok", 64'(want.single_ok), 64'(rsp_single_ok));
               compare_field("single_c", 64'($signed(want.single_c)),
                             64'(rsp_single_c));
               compare_field("scan_done", 64'(want.scan_done), 64'(rsp_scan_done));
               compare_field("scan_found", 64'(want.scan_found), 64'(rsp_scan_found));
               compare_field("scan_c", 64'($signed(want.scan_c)), 64'(rsp_scan_c));
               checked++;
               if (want.scan_done) begin
                  closed++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_readings.push_back(predict_reading(req_entry_valid,
               req_key_first_char, req_type_code, req_data_size, req_data_word,
               req_last));
         end
         // register writes; unknown indexes fall through
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SINGLE_LOW:  win_single_low  = int'($signed(csr_wdata));
               CSR_SINGLE_HIGH: win_single_high = int'($signed(csr_wdata));
               CSR_SCAN_LOW:    win_scan_low    = int'($signed(csr_wdata));
               CSR_SCAN_HIGH:   win_scan_high   = int'($signed(csr_wdata));
               default: ;
            endcase
         end
      end
      fail_count      <= mismatches;
      outstanding     <= expected_readings.size();
      results_checked <= checked;
      scans_closed    <= closed;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: bench top for sensor_value_decode_and_max_scan
// Drives directed and random sensor entries under several window settings,
// with random idle cycles on the entry side and random stalls on the result
// side; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   import svdms_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DRAIN_CYCLES    = 12;
   localparam int IDLE_PERCENT    = 37;

   // Key characters outside the scan
   localparam logic [7:0] KEY_OTHER = 8'h51;  // "Q"

   // Float bit patterns for the directed part
   localparam logic [31:0] FLT_POS_INF   = 32'h7F80_0000;
   localparam logic [31:0] FLT_NEG_INF   = 32'hFF80_0000;
   localparam logic [31:0] FLT_NAN       = 32'hFFC0_0001;
   localparam logic [31:0] FLT_TINY      = 32'h0000_0001;  // smallest subnormal
   localparam logic [31:0] FLT_HUGE      = 32'h7F7F_FFFF;  // largest finite
   localparam logic [31:0] FLT_NEG_SAT   = 32'hD300_0000;  // -2^39
   localparam logic [31:0] FLT_BELOW_SAT = 32'h5280_0000;  // 2^38
   localparam logic [31:0] FLT_HALF      = 32'h3F00_0000;
   localparam logic [31:0] FLT_NEG_HALF  = 32'hBF00_0000;
   localparam logic [31:0] FLT_MINUS_40  = 32'hC220_0000;
   localparam logic [31:0] FLT_NEAR_125  = 32'h42F9_FFFF;  // just under 125
   localparam logic [31:0] FLT_20_5      = 32'h41A4_0000;

   typedef struct packed {
      logic        entry_valid;
      logic [7:0]  key_first_char;
      logic [31:0] type_code;
      logic [5:0]  data_size;
      logic [31:0] data_word;
      logic        last;
   } sensor_entry_type;

   typedef enum {FMT_FLT, FMT_SP78, FMT_FPE2, FMT_UI32, FMT_UI8, FMT_NOISE} fmt_pick_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_entry_valid;
   logic [7:0]         req_key_first_char;
   logic [31:0]        req_type_code;
   logic [5:0]         req_data_size;
   logic [31:0]        req_data_word;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_decoded;
   logic               rsp_finite;
   logic signed [47:0] rsp_value_q8;
   logic               rsp_single_ok;
   logic signed [7:0]  rsp_single_c;
   logic               rsp_scan_done;
   logic               rsp_scan_found;
   logic signed [7:0]  rsp_scan_c;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [7:0]         csr_wdata;

   int  fail_count;
   int  outstanding;
   int  results_checked;
   int  scans_closed;
   int  entries_sent;
   int  cycle_count = 0;
   bit  quiet;
   cfg_type window_plan [6];

   sensor_value_decode_and_max_scan DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_entry_valid    (req_entry_valid),
      .req_key_first_char (req_key_first_char),
      .req_type_code      (req_type_code),
      .req_data_size      (req_data_size),
      .req_data_word      (req_data_word),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded        (rsp_decoded),
      .rsp_finite         (rsp_finite),
      .rsp_value_q8       (rsp_value_q8),
      .rsp_single_ok      (rsp_single_ok),
      .rsp_single_c       (rsp_single_c),
      .rsp_scan_done      (rsp_scan_done),
      .rsp_scan_found     (rsp_scan_found),
      .rsp_scan_c         (rsp_scan_c),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   svdms_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_entry_valid    (req_entry_valid),
      .req_key_first_char (req_key_first_char),
      .req_type_code      (req_type_code),
      .req_data_size      (req_data_size),
      .req_data_word      (req_data_word),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_decoded        (rsp_decoded),
      .rsp_finite         (rsp_finite),
      .rsp_value_q8       (rsp_value_q8),
      .rsp_single_ok      (rsp_single_ok),
      .rsp_single_c       (rsp_single_c),
      .rsp_scan_done      (rsp_scan_done),
      .rsp_scan_found     (rsp_scan_found),
      .rsp_scan_c         (rsp_scan_c),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .outstanding        (outstanding),
      .results_checked    (results_checked),
      .scans_closed       (scans_closed)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sensor_value_decode_and_max_scan test failed");
         $finish;
      end
   end

   // Random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
   end

   function automatic sensor_entry_type entry_of(
      input logic        ok,
      input logic [7:0]  key,
      input logic [31:0] kind,
      input logic [5:0]  size,
      input logic [31:0] word,
      input logic        last
   );
      sensor_entry_type e;
      e.entry_valid    = ok;
      e.key_first_char = key;
      e.type_code      = kind;
      e.data_size      = size;
      e.data_word      = word;
      e.last           = last;
      return e;
   endfunction

   // Mostly well-formed entries with values near the degree windows
   function automatic sensor_entry_type random_entry();
      sensor_entry_type e;
      int unsigned      pick;
      bit               shaped;
      e.entry_valid = ($urandom_range(19) != 0);
      pick = $urandom_range(9);
      e.key_first_char = (pick < 4) ? KEY_UPPER_T :
                         (pick < 7) ? KEY_LOWER_T : 8'($urandom_range(255));
      e.last      = ($urandom_range(11) == 0);
      e.data_word = $urandom();
      shaped      = ($urandom_range(99) < 75);
      case (fmt_pick_type'($urandom_range(5)))
         FMT_FLT: begin
            e.type_code = TYPE_FLT;
            e.data_size = SIZE_FLT;
            // magnitudes from about 1/512 up to just under 512 degrees
            if (shaped) e.data_word[30:23] = 8'($urandom_range(135, 118));
         end
         FMT_SP78: begin
            e.type_code = TYPE_SP78;
            e.data_size = SIZE_SP78;
            if (shaped) e.data_word[31:16] = 16'($urandom_range(65024) - 32512);
         end
         FMT_FPE2: begin
            e.type_code = TYPE_FPE2;
            e.data_size = SIZE_FPE2;
            if (shaped) e.data_word[31:16] = 16'($urandom_range(560));
         end
         FMT_UI32: begin
            e.type_code = TYPE_UI32;
            e.data_size = SIZE_UI32;
            if (shaped) e.data_word = $urandom_range(140);
         end
         FMT_UI8: begin
            e.type_code = TYPE_UI8;
            e.data_size = SIZE_UI8;
         end
         default: begin
            e.type_code = $urandom();
            e.data_size = 6'($urandom_range(32));
         end
      endcase
      // a size that rarely matches the type
      if ($urandom_range(11) == 0) e.data_size = 6'($urandom_range(32));
      return e;
   endfunction

   // Offer one entry word, with random idle cycles ahead of it unless quiet is set
   task automatic offer_entry(input sensor_entry_type e);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_entry_valid    <= e.entry_valid;
      req_key_first_char <= e.key_first_char;
      req_type_code      <= e.type_code;
      req_data_size      <= e.data_size;
      req_data_word      <= e.data_word;
      req_last           <= e.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      entries_sent++;
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Lower valid and wait for every expected word to come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_windows(input cfg_type w);
      write_reg(CSR_SINGLE_LOW, w.single_low);
      write_reg(CSR_SINGLE_HIGH, w.single_high);
      write_reg(CSR_SCAN_LOW, w.scan_low);
      write_reg(CSR_SCAN_HIGH, w.scan_high);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_entry_valid    = 1'b0;
      req_key_first_char = '0;
      req_type_code      = '0;
      req_data_size      = '0;
      req_data_word      = '0;
      req_last           = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      quiet              = 1'b0;
      entries_sent       = 0;

      // widest, empty, single point for the scan, narrow, random, back to reset values
      window_plan[0] = '{single_low: -8'sd128, single_high: 8'sd127,
                         scan_low: -8'sd128, scan_high: 8'sd127};
      window_plan[1] = '{single_low: 8'sd127, single_high: -8'sd128,
                         scan_low: 8'sd127, scan_high: -8'sd128};
      window_plan[2] = '{single_low: 8'sd0, single_high: 8'sd0,
                         scan_low: 8'sd0, scan_high: 8'sd0};
      window_plan[3] = '{single_low: -8'sd20, single_high: 8'sd60,
                         scan_low: -8'sd10, scan_high: 8'sd40};
      window_plan[4] = '{single_low: 8'($urandom_range(255)),
                         single_high: 8'($urandom_range(255)),
                         scan_low: 8'($urandom_range(255)),
                         scan_high: 8'($urandom_range(255))};
      window_plan[5] = '{single_low: RST_SINGLE_LOW, single_high: RST_SINGLE_HIGH,
                         scan_low: RST_SCAN_LOW, scan_high: RST_SCAN_HIGH};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed entries under the reset windows
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_UI8, SIZE_UI8, 32'h0000_0000, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_UI8, SIZE_UI8, 32'hFF00_0000, 1'b0));
      offer_entry(entry_of(1'b1, KEY_LOWER_T, TYPE_UI8, SIZE_UI8, 32'h6400_0000, 1'b0));
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_UI32, SIZE_UI32, 32'hFFFF_FFFF, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_SP78, SIZE_SP78, 32'h7FFF_0000, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_SP78, SIZE_SP78, 32'h8000_FFFF, 1'b0));
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_FPE2, SIZE_FPE2, 32'hFFFF_0000, 1'b0));
      // scan closes here; the ui8 100 entry holds its maximum
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_FPE2, SIZE_FPE2, 32'h0000_FFFF, 1'b1));
      // non-finite floats, subnormal, saturation both ways
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, SIZE_FLT, FLT_POS_INF, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, SIZE_FLT, FLT_NAN, 1'b0));
      offer_entry(entry_of(1'b1, KEY_LOWER_T, TYPE_FLT, SIZE_FLT, FLT_NEG_INF, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, SIZE_FLT, FLT_TINY, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, SIZE_FLT, FLT_HUGE, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, SIZE_FLT, FLT_NEG_SAT, 1'b0));
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_FLT, SIZE_FLT, FLT_BELOW_SAT, 1'b0));
      // rounding at a half, and the single window bounds
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_FLT, SIZE_FLT, FLT_HALF, 1'b0));
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_FLT, SIZE_FLT, FLT_NEG_HALF, 1'b0));
      offer_entry(entry_of(1'b1, KEY_OTHER, TYPE_FLT, SIZE_FLT, FLT_MINUS_40, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, SIZE_FLT, FLT_NEAR_125, 1'b0));
      // unknown type, oversize, invalid entry
      offer_entry(entry_of(1'b1, KEY_UPPER_T, ~TYPE_FLT, SIZE_FLT, 32'h4200_0000, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_FLT, 6'd32, 32'h4200_0000, 1'b0));
      offer_entry(entry_of(1'b0, KEY_UPPER_T, TYPE_UI8, SIZE_UI8, 32'h3200_0000, 1'b0));
      // scan closes with nothing in the window
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_UI8, SIZE_UI8, 32'h0300_0000, 1'b1));
      // float and sp78 competing for the maximum
      offer_entry(entry_of(1'b1, KEY_LOWER_T, TYPE_FLT, SIZE_FLT, FLT_20_5, 1'b0));
      offer_entry(entry_of(1'b1, KEY_UPPER_T, TYPE_SP78, SIZE_SP78, 32'h14C0_0000, 1'b1));
      drain();

      // Random entries under each window setting
      foreach (window_plan[p]) begin
         set_windows(window_plan[p]);
         // indexes past the last register must be ignored
         if (p == 4) write_reg(8'($urandom_range(255, 4)), 8'($urandom_range(255)));
         quiet = (p == 0);
         repeat (ITEMS_PER_PHASE) offer_entry(random_entry());
         drain();
         quiet = 1'b0;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d entries sent under %0d window settings plus the reset windows",
               entries_sent, $size(window_plan));
      $display("%0d result words checked, %0d scans closed", results_checked, scans_closed);
      if (fail_count == 0 && outstanding == 0) begin
         $display("sensor_value_decode_and_max_scan test passed");
      end else begin
         $display("sensor_value_decode_and_max_scan test failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/svdms_pkg.sv
rtl/core/svdms_front.sv
rtl/core/svdms_queue.sv
rtl/core/svdms_back.sv
rtl/core/sensor_value_decode_and_max_scan.sv
bench/svdms_checker.sv
bench/tb.sv
